// ===== hdl/mbe_pkg.sv =====
`timescale 1ns / 1ps

package mbe_pkg;

	localparam int PIX_W         = 12;
	localparam int CFG_W         = 32;
	localparam int SIZE_W        = 13;
	localparam int LIM_W         = 16;
	localparam int IDX_W         = 3;
	localparam int DIFF_W        = CFG_W + 1;
	localparam int MUL_W         = 33;
	localparam int HALF_W        = 32;
	localparam int PROD_W        = PIX_W + DIFF_W;
	localparam int C_W           = PROD_W + 1;
	localparam int Z_W           = 64;
	localparam int ACC_W         = 128;
	localparam int MUL_STEPS     = 12;
	localparam int STEP_W        = 4;
	localparam int FRAC_BITS_DEF = 28;

	localparam logic [IDX_W-1:0] REG_REAL_START = 3'd0;
	localparam logic [IDX_W-1:0] REG_REAL_END   = 3'd1;
	localparam logic [IDX_W-1:0] REG_IMAG_START = 3'd2;
	localparam logic [IDX_W-1:0] REG_IMAG_END   = 3'd3;
	localparam logic [IDX_W-1:0] REG_WIDTH      = 3'd4;
	localparam logic [IDX_W-1:0] REG_HEIGHT     = 3'd5;
	localparam logic [IDX_W-1:0] REG_ITER_LIMIT = 3'd6;

	localparam logic [CFG_W-1:0]  RST_REAL_START = 32'hE000_0000;
	localparam logic [CFG_W-1:0]  RST_REAL_END   = 32'h1000_0000;
	localparam logic [CFG_W-1:0]  RST_IMAG_START = 32'hF000_0000;
	localparam logic [CFG_W-1:0]  RST_IMAG_END   = 32'h1000_0000;
	localparam logic [SIZE_W-1:0] RST_WIDTH      = 13'd640;
	localparam logic [SIZE_W-1:0] RST_HEIGHT     = 13'd480;
	localparam logic [LIM_W-1:0]  RST_ITER_LIMIT = 16'd256;

	typedef struct packed {
		logic [CFG_W-1:0]  real_start;
		logic [CFG_W-1:0]  real_end;
		logic [CFG_W-1:0]  imag_start;
		logic [CFG_W-1:0]  imag_end;
		logic [SIZE_W-1:0] width;
		logic [SIZE_W-1:0] height;
		logic [LIM_W-1:0]  iter_limit;
	} cfg_t;

	typedef struct packed {
		logic [PIX_W-1:0] col;
		logic [PIX_W-1:0] row;
		logic [LIM_W-1:0] iter_count;
		logic             inside_set;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAP_MUL,
		ST_MAP_DIV,
		ST_TEST,
		ST_MUL,
		ST_SUM,
		ST_UPDATE,
		ST_DONE
	} state_t;

endpackage

// ===== hdl/mbe_mul.sv =====
`timescale 1ns / 1ps

module mbe_mul (
	input  logic                         clk,
	input  logic                         en,
	input  logic [mbe_pkg::MUL_W-1:0]    a,
	input  logic [mbe_pkg::MUL_W-1:0]    b,
	output logic [2*mbe_pkg::MUL_W-1:0]  p_s1
);

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1 <= a * b;
		end
	end

endmodule

// ===== hdl/mbe_div.sv =====
`timescale 1ns / 1ps

module mbe_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [mbe_pkg::PROD_W-1:0]    dividend,
	input  logic [mbe_pkg::SIZE_W-1:0]    divisor,
	output logic                          done,
	output logic [mbe_pkg::PROD_W-1:0]    quotient
);

	localparam int N     = mbe_pkg::PROD_W;
	localparam int DW    = mbe_pkg::SIZE_W;
	localparam int CNT_W = $clog2(N + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    dvs_q;
	logic [N-1:0]     quo_q;

	logic [DW:0] rem_shift;
	logic [DW:0] rem_next;
	logic        take;

	always_comb begin
		rem_shift = {rem_q, quo_q[N-1]};
		take      = rem_shift >= {1'b0, dvs_q};
		rem_next  = take ? (rem_shift - {1'b0, dvs_q}) : rem_shift;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(N);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= rem_next[DW-1:0];
			quo_q <= {quo_q[N-2:0], take};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== hdl/mbe_core.sv =====
`timescale 1ns / 1ps

module mbe_core #(
	parameter int FRAC_BITS = mbe_pkg::FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mbe_pkg::cfg_t              cfg,
	input  logic                       in_valid,
	input  logic [mbe_pkg::PIX_W-1:0]  in_col,
	input  logic [mbe_pkg::PIX_W-1:0]  in_row,
	output logic                       in_ready,
	output logic                       res_valid,
	output mbe_pkg::res_t              res,
	input  logic                       res_ready
);

	localparam int PIX_W  = mbe_pkg::PIX_W;
	localparam int CFG_W  = mbe_pkg::CFG_W;
	localparam int DIFF_W = mbe_pkg::DIFF_W;
	localparam int MUL_W  = mbe_pkg::MUL_W;
	localparam int HALF_W = mbe_pkg::HALF_W;
	localparam int PROD_W = mbe_pkg::PROD_W;
	localparam int C_W    = mbe_pkg::C_W;
	localparam int Z_W    = mbe_pkg::Z_W;
	localparam int ACC_W  = mbe_pkg::ACC_W;
	localparam int LIM_W  = mbe_pkg::LIM_W;
	localparam int STEP_W = mbe_pkg::STEP_W;

	localparam logic [1:0] PP_SR = 2'd0;
	localparam logic [1:0] PP_SI = 2'd1;
	localparam logic [1:0] PP_SX = 2'd2;

	localparam logic [ACC_W:0] ESC_BOUND = {{ACC_W{1'b0}}, 1'b1} << (2 * FRAC_BITS + 2);

	mbe_pkg::state_t state_q, state_d;

	logic [STEP_W-1:0] step_q;
	logic              axis_q;
	logic [LIM_W-1:0]  n_q;
	logic [PIX_W-1:0]  col_q, row_q;
	logic [C_W-1:0]    cr_q, ci_q;
	logic [Z_W-1:0]    zr_q, zi_q;
	logic [Z_W-1:0]    ar_q, ai_q;
	logic [ACC_W-1:0]  sr_q, si_q, sx_q;
	logic [ACC_W-1:0]  diff_q;
	logic              neg_re_q;
	logic [STEP_W-1:0] pp_idx_s1;

	logic                 mul_en;
	logic [MUL_W-1:0]     mul_a, mul_b;
	logic [2*MUL_W-1:0]   mul_p;
	logic                 div_start;
	logic                 div_done;
	logic [PROD_W-1:0]    div_q;

	logic [CFG_W-1:0]  map_start, map_end;
	logic [DIFF_W-1:0] dlt, dmag;
	logic              dneg;
	logic [PROD_W-1:0] q_eff;
	logic [C_W-1:0]    s_ext, q_ext, c_new;

	logic [ACC_W:0]   sum_w;
	logic             escape;
	logic             sr_ge;
	logic [ACC_W-1:0] diff_new;

	logic [Z_W-1:0]   re_mag, im_mag, cr_ext, ci_ext, zr_new, zi_new;
	logic             neg_im;
	logic [ACC_W-1:0] addend;
	logic [1:0]       pp_sh;

	logic start;
	assign start = in_valid && in_ready;

	mbe_mul u_mul (
		.clk  (clk),
		.en   (mul_en),
		.a    (mul_a),
		.b    (mul_b),
		.p_s1 (mul_p)
	);

	mbe_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mul_p[PROD_W-1:0]),
		.divisor  (axis_q ? cfg.height : cfg.width),
		.done     (div_done),
		.quotient (div_q)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			mbe_pkg::ST_IDLE: begin
				if (in_valid) state_d = mbe_pkg::ST_MAP_MUL;
			end
			mbe_pkg::ST_MAP_MUL: begin
				if (step_q != '0) state_d = mbe_pkg::ST_MAP_DIV;
			end
			mbe_pkg::ST_MAP_DIV: begin
				if (div_done) state_d = axis_q ? mbe_pkg::ST_TEST : mbe_pkg::ST_MAP_MUL;
			end
			mbe_pkg::ST_TEST: begin
				state_d = (n_q >= cfg.iter_limit) ? mbe_pkg::ST_DONE : mbe_pkg::ST_MUL;
			end
			mbe_pkg::ST_MUL: begin
				if (step_q == STEP_W'(mbe_pkg::MUL_STEPS)) state_d = mbe_pkg::ST_SUM;
			end
			mbe_pkg::ST_SUM: begin
				state_d = escape ? mbe_pkg::ST_DONE : mbe_pkg::ST_UPDATE;
			end
			mbe_pkg::ST_UPDATE: begin
				state_d = mbe_pkg::ST_TEST;
			end
			mbe_pkg::ST_DONE: begin
				if (res_ready) state_d = mbe_pkg::ST_IDLE;
			end
			default: begin
				state_d = mbe_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		res_valid = 1'b0;
		mul_en    = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		case (state_q)
			mbe_pkg::ST_IDLE: begin
				in_ready = 1'b1;
			end
			mbe_pkg::ST_MAP_MUL: begin
				mul_en    = (step_q == '0);
				mul_a     = {{(MUL_W-PIX_W){1'b0}}, (axis_q ? row_q : col_q)};
				mul_b     = dmag;
				div_start = (step_q != '0);
			end
			mbe_pkg::ST_MUL: begin
				mul_en = 1'b1;
				case (step_q[3:2])
					PP_SR: begin
						mul_a = {1'b0, (step_q[1] ? ar_q[Z_W-1:HALF_W] : ar_q[HALF_W-1:0])};
						mul_b = {1'b0, (step_q[0] ? ar_q[Z_W-1:HALF_W] : ar_q[HALF_W-1:0])};
					end
					PP_SI: begin
						mul_a = {1'b0, (step_q[1] ? ai_q[Z_W-1:HALF_W] : ai_q[HALF_W-1:0])};
						mul_b = {1'b0, (step_q[0] ? ai_q[Z_W-1:HALF_W] : ai_q[HALF_W-1:0])};
					end
					PP_SX: begin
						mul_a = {1'b0, (step_q[1] ? ar_q[Z_W-1:HALF_W] : ar_q[HALF_W-1:0])};
						mul_b = {1'b0, (step_q[0] ? ai_q[Z_W-1:HALF_W] : ai_q[HALF_W-1:0])};
					end
					default: begin
						mul_a = '0;
						mul_b = '0;
					end
				endcase
			end
			mbe_pkg::ST_DONE: begin
				res_valid = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_comb begin
		map_start = axis_q ? cfg.imag_start : cfg.real_start;
		map_end   = axis_q ? cfg.imag_end : cfg.real_end;
		dlt       = {map_end[CFG_W-1], map_end} - {map_start[CFG_W-1], map_start};
		dneg      = dlt[DIFF_W-1];
		dmag      = dneg ? (~dlt + 1'b1) : dlt;
		q_eff     = ((axis_q ? cfg.height : cfg.width) == '0) ? '0 : div_q;
		s_ext     = {{(C_W-CFG_W){map_start[CFG_W-1]}}, map_start};
		q_ext     = {1'b0, q_eff};
		c_new     = dneg ? (s_ext - q_ext) : (s_ext + q_ext);

		sum_w    = {1'b0, sr_q} + {1'b0, si_q};
		escape   = sum_w > ESC_BOUND;
		sr_ge    = si_q <= sr_q;
		diff_new = sr_ge ? (sr_q - si_q) : (si_q - sr_q);

		re_mag = diff_q[FRAC_BITS +: Z_W];
		im_mag = sx_q[FRAC_BITS-1 +: Z_W];
		neg_im = zr_q[Z_W-1] ^ zi_q[Z_W-1];
		cr_ext = {{(Z_W-C_W){cr_q[C_W-1]}}, cr_q};
		ci_ext = {{(Z_W-C_W){ci_q[C_W-1]}}, ci_q};
		zr_new = neg_re_q ? (cr_ext - re_mag) : (cr_ext + re_mag);
		zi_new = neg_im ? (ci_ext - im_mag) : (ci_ext + im_mag);

		pp_sh  = {1'b0, pp_idx_s1[1]} + {1'b0, pp_idx_s1[0]};
		addend = {{(ACC_W-2*MUL_W){1'b0}}, mul_p} << (HALF_W * pp_sh);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mbe_pkg::ST_IDLE;
			step_q  <= '0;
			axis_q  <= 1'b0;
			n_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) begin
				step_q <= '0;
			end else if (state_q == mbe_pkg::ST_MAP_MUL || state_q == mbe_pkg::ST_MUL) begin
				step_q <= step_q + 1'b1;
			end
			if (start) begin
				axis_q <= 1'b0;
				n_q    <= '0;
			end else begin
				if (state_q == mbe_pkg::ST_MAP_DIV && div_done) axis_q <= 1'b1;
				if (state_q == mbe_pkg::ST_UPDATE) n_q <= n_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			col_q <= in_col;
			row_q <= in_row;
			zr_q  <= '0;
			zi_q  <= '0;
		end
		if (state_q == mbe_pkg::ST_MAP_DIV && div_done) begin
			if (axis_q) ci_q <= c_new;
			else cr_q <= c_new;
		end
		if (state_q == mbe_pkg::ST_TEST) begin
			ar_q <= zr_q[Z_W-1] ? (~zr_q + 1'b1) : zr_q;
			ai_q <= zi_q[Z_W-1] ? (~zi_q + 1'b1) : zi_q;
			sr_q <= '0;
			si_q <= '0;
			sx_q <= '0;
		end
		if (state_q == mbe_pkg::ST_MUL) begin
			pp_idx_s1 <= step_q;
			if (step_q != '0) begin
				case (pp_idx_s1[3:2])
					PP_SR:   sr_q <= sr_q + addend;
					PP_SI:   si_q <= si_q + addend;
					PP_SX:   sx_q <= sx_q + addend;
					default: sx_q <= sx_q;
				endcase
			end
		end
		if (state_q == mbe_pkg::ST_SUM) begin
			diff_q   <= diff_new;
			neg_re_q <= !sr_ge;
		end
		if (state_q == mbe_pkg::ST_UPDATE) begin
			zr_q <= zr_new;
			zi_q <= zi_new;
		end
	end

	assign res.col        = col_q;
	assign res.row        = row_q;
	assign res.iter_count = n_q;
	assign res.inside_set = (n_q >= cfg.iter_limit);

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != mbe_pkg::ST_IDLE) |-> (n_q <= cfg.iter_limit))
		else $error("iteration count passed the limit");

	a_start_clean: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> (state_q == mbe_pkg::ST_MAP_MUL && n_q == '0 && !axis_q))
		else $error("item did not start from a clean state");

	a_sum_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mbe_pkg::ST_SUM) |-> ($past(state_q) == mbe_pkg::ST_MUL))
		else $error("escape test without fresh products");

	a_update_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mbe_pkg::ST_UPDATE) |->
		(diff_q[ACC_W-1:FRAC_BITS+Z_W-1] == '0 && sx_q[ACC_W-1:FRAC_BITS+Z_W-2] == '0))
		else $error("update term does not fit the z register");
`endif

endmodule

// ===== hdl/mandelbrot_escape_time.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake               Content
// s_axis    in         s_tvalid / s_tready     one pixel coordinate item
// m_axis    out        m_tvalid / m_tready     one escape-time result item
// cfg       in         cfg_we                  register write, no read-back
//
// Each axis mapping runs the shared 33 x 33 multiplier and then the divider; each iteration is
// set by the twelve partial products of that multiplier.
// s_tready is high only in idle, so the next item can be accepted in the cycle after the result moves on.
// The output register holds a finished item while the next one is processed; a stalled output
// stalls the core once its item is done. Reset is asynchronous and active low.

module mandelbrot_escape_time #(
	parameter int FRAC_BITS = mbe_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [23:0]                   s_tdata,   // pixel_col, pixel_row
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [39:0]                   m_tdata,   // out_col, out_row, iter_count
	output logic                          m_tuser,   // inside_set
	input  logic                          cfg_we,
	input  logic [mbe_pkg::IDX_W-1:0]     cfg_index,
	input  logic [mbe_pkg::CFG_W-1:0]     cfg_data
);

	localparam int PIX_W = mbe_pkg::PIX_W;
	localparam int LIM_W = mbe_pkg::LIM_W;

	mbe_pkg::cfg_t cfg_q;
	mbe_pkg::res_t res;
	mbe_pkg::res_t out_q;
	logic          res_valid;
	logic          out_free;
	logic          m_tvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.real_start <= mbe_pkg::RST_REAL_START;
			cfg_q.real_end   <= mbe_pkg::RST_REAL_END;
			cfg_q.imag_start <= mbe_pkg::RST_IMAG_START;
			cfg_q.imag_end   <= mbe_pkg::RST_IMAG_END;
			cfg_q.width      <= mbe_pkg::RST_WIDTH;
			cfg_q.height     <= mbe_pkg::RST_HEIGHT;
			cfg_q.iter_limit <= mbe_pkg::RST_ITER_LIMIT;
		end else if (cfg_we) begin
			case (cfg_index)
				mbe_pkg::REG_REAL_START: cfg_q.real_start <= cfg_data;
				mbe_pkg::REG_REAL_END:   cfg_q.real_end   <= cfg_data;
				mbe_pkg::REG_IMAG_START: cfg_q.imag_start <= cfg_data;
				mbe_pkg::REG_IMAG_END:   cfg_q.imag_end   <= cfg_data;
				mbe_pkg::REG_WIDTH:      cfg_q.width      <= cfg_data[mbe_pkg::SIZE_W-1:0];
				mbe_pkg::REG_HEIGHT:     cfg_q.height     <= cfg_data[mbe_pkg::SIZE_W-1:0];
				mbe_pkg::REG_ITER_LIMIT: cfg_q.iter_limit <= cfg_data[LIM_W-1:0];
				default:                 cfg_q            <= cfg_q;
			endcase
		end
	end

	assign out_free = !m_tvalid_q || m_tready;

	mbe_core #(
		.FRAC_BITS (FRAC_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_tvalid),
		.in_col    (s_tdata[PIX_W-1:0]),
		.in_row    (s_tdata[2*PIX_W-1:PIX_W]),
		.in_ready  (s_tready),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (out_free)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_free) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {out_q.iter_count, out_q.row, out_q.col};
	assign m_tuser  = out_q.inside_set;

endmodule
